@@ hdl/tga_pkg.sv @@
package tga_pkg;

    // pixel depth register
    localparam int unsigned TGA_PB_W        = 3;
    localparam logic [2:0]  TGA_PB_RESET    = 3'd4;
    localparam logic [2:0]  TGA_PB_MIN      = 3'd1;
    localparam logic [2:0]  TGA_PB_MAX      = 3'd4;

    // packet header layout
    localparam int unsigned TGA_RUN_BIT     = 7;
    localparam logic [7:0]  TGA_COUNT_MASK  = 8'b0111_1111;

    // result field widths
    localparam int unsigned TGA_PIX_W       = 32;
    localparam int unsigned TGA_REP_W       = 8;

    // result queue between front and back
    localparam int unsigned TGA_QDEPTH      = 2;
    localparam int unsigned TGA_QPTR_W      = $clog2(TGA_QDEPTH);
    localparam int unsigned TGA_QCNT_W      = $clog2(TGA_QDEPTH + 1);

    // one queued result command
    typedef struct packed {
        logic                 trunc;
        logic                 last;
        logic [TGA_REP_W-1:0] repeat_count;
        logic [TGA_PIX_W-1:0] pixel_value;
    } t_tga_cmd;

endpackage

@@ hdl/tga_front.sv @@
module tga_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [2:0]       i_pixel_bytes,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_final_byte,
    input  logic             i_q_full,
    output logic             o_push,
    output tga_pkg::t_tga_cmd o_cmd
);
    import tga_pkg::*;

    logic        r_expect_header, n_expect_header;
    logic        r_run_packet,    n_run_packet;
    logic [7:0]  r_pixels_left,   n_pixels_left;
    logic [1:0]  r_byte_pos,      n_byte_pos;
    logic [31:0] r_gather,        n_gather;

    logic        accept;
    logic [2:0]  eff_bytes;
    logic [2:0]  gathered;
    logic [31:0] merged;
    logic [7:0]  left_after;
    logic [7:0]  rep;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    // 0 acts as 1, above 4 acts as 4
    always_comb begin
        if (i_pixel_bytes == 3'd0) begin
            eff_bytes = TGA_PB_MIN;
        end else if (i_pixel_bytes > TGA_PB_MAX) begin
            eff_bytes = TGA_PB_MAX;
        end else begin
            eff_bytes = i_pixel_bytes;
        end
    end

    always_comb begin
        merged = r_gather;
        unique case (r_byte_pos)
            2'd0: merged[7:0]   = i_data_byte;
            2'd1: merged[15:8]  = i_data_byte;
            2'd2: merged[23:16] = i_data_byte;
            2'd3: merged[31:24] = i_data_byte;
            default: merged = r_gather;
        endcase
    end

    assign gathered = {1'b0, r_byte_pos} + 3'd1;

    always_comb begin
        n_expect_header = r_expect_header;
        n_run_packet    = r_run_packet;
        n_pixels_left   = r_pixels_left;
        n_byte_pos      = r_byte_pos;
        n_gather        = r_gather;
        o_push          = 1'b0;
        o_cmd           = '0;
        left_after      = r_pixels_left;
        rep             = 8'd1;

        if (accept) begin
            if (r_expect_header) begin
                if (i_final_byte) begin
                    // buffer ends on a header: packet has no pixels
                    o_push     = 1'b1;
                    o_cmd.trunc = 1'b1;
                    o_cmd.last  = 1'b1;
                end else begin
                    n_run_packet    = i_data_byte[TGA_RUN_BIT];
                    n_pixels_left   = (i_data_byte & TGA_COUNT_MASK) + 8'd1;
                    n_byte_pos      = 2'd0;
                    n_gather        = '0;
                    n_expect_header = 1'b0;
                end
            end else if (gathered < eff_bytes) begin
                n_byte_pos = gathered[1:0];
                n_gather   = merged;
                if (i_final_byte) begin
                    o_push      = 1'b1;
                    o_cmd.trunc = 1'b1;
                    o_cmd.last  = 1'b1;
                end
            end else begin
                n_byte_pos = 2'd0;
                n_gather   = '0;
                if (r_run_packet) begin
                    rep        = r_pixels_left;
                    left_after = 8'd0;
                end else begin
                    rep        = 8'd1;
                    left_after = (r_pixels_left != 8'd0) ? r_pixels_left - 8'd1 : 8'd0;
                end
                n_pixels_left = left_after;
                o_push        = 1'b1;
                if (left_after == 8'd0) begin
                    n_expect_header    = 1'b1;
                    n_run_packet       = 1'b0;
                    o_cmd.pixel_value  = merged;
                    o_cmd.repeat_count = rep;
                    o_cmd.last         = i_final_byte;
                end else if (i_final_byte) begin
                    o_cmd.trunc = 1'b1;
                    o_cmd.last  = 1'b1;
                end else begin
                    o_cmd.pixel_value  = merged;
                    o_cmd.repeat_count = rep;
                end
            end

            // truncation voids the image and restarts on a header
            if (o_cmd.trunc) begin
                n_expect_header = 1'b1;
                n_run_packet    = 1'b0;
                n_pixels_left   = 8'd0;
                n_byte_pos      = 2'd0;
                n_gather        = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_run_packet    <= 1'b0;
            r_pixels_left   <= 8'd0;
            r_byte_pos      <= 2'd0;
        end else begin
            r_expect_header <= n_expect_header;
            r_run_packet    <= n_run_packet;
            r_pixels_left   <= n_pixels_left;
            r_byte_pos      <= n_byte_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gather <= n_gather;
    end

endmodule

@@ hdl/tga_queue.sv @@
module tga_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tga_pkg::t_tga_cmd i_cmd,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output tga_pkg::t_tga_cmd o_cmd
);
    import tga_pkg::*;

    t_tga_cmd              r_mem [TGA_QDEPTH];
    logic [TGA_QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [TGA_QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [TGA_QCNT_W-1:0] r_count,  n_count;
    logic                  do_pop;

    localparam logic [TGA_QPTR_W-1:0] LastPtr = TGA_QPTR_W'(TGA_QDEPTH - 1);
    localparam logic [TGA_QCNT_W-1:0] FullCnt = TGA_QCNT_W'(TGA_QDEPTH);

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign do_pop  = i_pop && o_valid;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ hdl/tga_back.sv @@
module tga_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_pop,
    input  tga_pkg::t_tga_cmd i_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [39:0]       o_data,
    output logic              o_user,
    output logic              o_last
);
    import tga_pkg::*;

    logic                 r_valid, n_valid;
    logic [TGA_PIX_W-1:0] r_value;
    logic [TGA_REP_W-1:0] r_repeat;
    logic                 r_trunc;
    logic                 r_last;
    logic                 load;

    assign load    = i_q_valid && (!r_valid || i_ready);
    assign o_q_pop = load;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // a truncation word carries zero pixel and zero repeat
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value  <= i_cmd.trunc ? '0 : i_cmd.pixel_value;
            r_repeat <= i_cmd.trunc ? '0 : i_cmd.repeat_count;
            r_trunc  <= i_cmd.trunc;
            r_last   <= i_cmd.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {r_repeat, r_value};
    assign o_user  = r_trunc;
    assign o_last  = r_last;

endmodule

@@ hdl/tga_rle_pixel_decoder.sv @@
// tga run-length pixel decoder: takes the compressed image data one byte per
// word on the slave stream (tlast on the final byte of the buffer) and gives
// decoded pixel words on the master stream. a run packet yields a single
// word whose repeat count is the run length, for a downstream expander; a
// literal packet yields one word per pixel with repeat count 1. if the buffer
// ends inside a packet, or on a header byte, one truncation word (tuser high,
// tlast high, pixel and count zero) ends and voids the image, and the decoder
// restarts on a header. pixel depth in bytes (1 to 4, reset 4) is written on the
// config channel while the stream is idle; 0 acts as 1 and 5 to 7 as 4.
// throughput is one byte per cycle while the result queue has room: the
// header/pixel parser takes a byte every clock and pushes results into a
// two-entry queue, which an output register drains; s_axis_tready drops only
// while that queue is full, so a stalled sink holds off input after three
// pending results, two queued and one in the output register. the word for
// a finished pixel passes through the queue and then the output register.
module tga_rle_pixel_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // config channel: pixel bytes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,

    // compressed byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // final_byte

    // decoded pixel stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] pixel_value, [39:32] repeat_count
    output logic        m_axis_tuser,   // truncated
    output logic        m_axis_tlast    // image_end
);
    import tga_pkg::*;

    logic [TGA_PB_W-1:0] r_pixel_bytes;

    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    logic     push;
    t_tga_cmd push_cmd;
    t_tga_cmd head_cmd;

    // register always takes a write at once
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes <= TGA_PB_RESET;
        end else if (i_cfg_valid) begin
            r_pixel_bytes <= i_cfg_data;
        end
    end

    // front: packet header and pixel byte parser
    tga_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_bytes (r_pixel_bytes),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_data_byte   (s_axis_tdata),
        .i_final_byte  (s_axis_tlast),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // result queue decouples parser from the sink
    tga_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd)
    );

    // back: output register and word formatting
    tga_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_cmd     (head_cmd),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule
